// ===== src/ggle_pkg.sv =====
// shared types and constants for the gray / gaussian / laplacian edge mask unit
// no dependencies
package ggle_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_RED     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_GREEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BLUE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 3'd5;

  localparam int MIN_SIZE       = 5;
  localparam int WIDTH_RESET    = 640;
  localparam int HEIGHT_RESET   = 480;
  localparam logic [10:0] WEIGHT_RED_RESET   = 11'd306;
  localparam logic [10:0] WEIGHT_GREEN_RESET = 11'd601;
  localparam logic [10:0] WEIGHT_BLUE_RESET  = 11'd117;
  localparam logic signed [10:0] THRESHOLD_RESET = 11'sd3;

  typedef logic [10:0] weight_t;
  typedef logic signed [10:0] thr_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       flush;
  } pix_t;

  typedef struct packed {
    logic       edge_res;
    logic [7:0] smoothed;
    logic       last_of_frame;
  } res_t;

  // per-item control flags carried down the pipeline
  typedef struct packed {
    logic smask;     // smoothed position lies inside the two-pixel border
    logic out_vld;   // item produces a result
    logic out_last;  // result is the frame's final pixel
    logic inner;     // result position lies inside the one-pixel border
    logic cmask;     // result centre lies inside the two-pixel border
  } tag_t;

  // one column of the smoothed 3x3 window, r0 is the newest row
  typedef struct packed {
    logic [7:0] r0;
    logic [7:0] r1;
    logic [7:0] r2;
  } scol_t;

endpackage

// ===== src/gray_gauss_laplace_edge_mask_unit.sv =====
// Streaming edge mask: one BGR pixel beat per clock in, one result beat per clock out
// unless res_ready stalls. A result beat is registered after the beat that completes it
// has passed the gray and smoothing stages; results belong to the pixel 3*W+3 items
// back, so W*H pixel beats are followed by 3*W+3 flush beats to drain a frame.
// The pace is set by one read-modify-write per item on each line memory (gray: four
// rows, smoothed: two rows, one word per column). Memories are never cleared; the
// border masks keep unwritten entries out of every result. The user writes sizes and
// weights only while idle; the unit does not check. A size write restarts the frame.
// depends on ggle_pkg, ggle_pos, ggle_gray_col, ggle_smooth_win
module gray_gauss_laplace_edge_mask_unit #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pix_valid,
  output logic                                pix_ready,
  input  ggle_pkg::pix_t                      pix,
  output logic                                res_valid,
  input  logic                                res_ready,
  output ggle_pkg::res_t                      res,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ggle_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ggle_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ggle_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int HW = $clog2(MAX_HEIGHT+1);
  localparam logic [WW-1:0] W_RST = WW'((WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET);
  localparam logic [HW-1:0] H_RST =
    HW'((HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET);

  logic [WW-1:0] frame_width;
  logic [HW-1:0] frame_height;
  weight_t       weight_red, weight_green, weight_blue;
  thr_t          edge_threshold;

  logic          en, acc, cfg_wr, restart;
  logic [12:0]   sz;
  logic [WW-1:0] width_next;
  logic [HW-1:0] height_next;

  logic [CW-1:0] gx, sx, sx3;
  tag_t          tag0, tag3, tag5;
  logic          valid3, valid5;
  logic [11:0]   vsum;
  scol_t [2:0]   win;

  logic [9:0]         sum4;
  logic signed [11:0] lap;
  logic signed [11:0] thr12;
  logic               edge_bit;

  assign en        = !res_valid || res_ready;
  assign pix_ready = en;
  assign acc       = pix_valid && en;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign restart   = cfg_wr &&
                     (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  // sizes saturate to the supported range
  always_comb begin
    sz = {1'b0, cfg_data};
    if (sz < 13'(MIN_SIZE)) begin
      width_next  = WW'(MIN_SIZE);
      height_next = HW'(MIN_SIZE);
    end else begin
      width_next  = (32'(sz) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(sz);
      height_next = (32'(sz) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(sz);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= W_RST;
      frame_height   <= H_RST;
      weight_red     <= WEIGHT_RED_RESET;
      weight_green   <= WEIGHT_GREEN_RESET;
      weight_blue    <= WEIGHT_BLUE_RESET;
      edge_threshold <= THRESHOLD_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_FRAME_WIDTH:    frame_width    <= width_next;
        REG_FRAME_HEIGHT:   frame_height   <= height_next;
        REG_WEIGHT_RED:     weight_red     <= cfg_data[10:0];
        REG_WEIGHT_GREEN:   weight_green   <= cfg_data[10:0];
        REG_WEIGHT_BLUE:    weight_blue    <= cfg_data[10:0];
        REG_EDGE_THRESHOLD: edge_threshold <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  ggle_pos #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_pos (
    .clk(clk), .rst(rst), .acc(acc), .restart(restart),
    .w(frame_width), .h(frame_height), .gx(gx), .sx(sx), .tag(tag0)
  );

  ggle_gray_col #(.MAX_WIDTH(MAX_WIDTH)) u_gray (
    .clk(clk), .rst(rst), .en(en), .acc(acc), .pix(pix), .tag_in(tag0),
    .gx(gx), .sx_in(sx), .wr(weight_red), .wg(weight_green), .wb(weight_blue),
    .valid3(valid3), .tag3(tag3), .sx3(sx3), .vsum(vsum)
  );

  ggle_smooth_win #(.MAX_WIDTH(MAX_WIDTH)) u_smooth (
    .clk(clk), .rst(rst), .en(en), .valid3(valid3), .tag3(tag3), .sx3(sx3),
    .vsum(vsum), .valid5(valid5), .tag5(tag5), .win(win)
  );

  // 4-neighbour laplacian around the window centre
  always_comb begin
    sum4     = 10'(win[1].r2) + 10'(win[2].r1) + 10'(win[0].r1) + 10'(win[1].r0);
    lap      = $signed({2'b0, sum4}) - $signed({2'b0, win[1].r1, 2'b0});
    thr12    = {edge_threshold[10], edge_threshold};
    edge_bit = tag5.inner && (lap > thr12);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= valid5 && tag5.out_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.edge_res      <= edge_bit;
      res.smoothed      <= tag5.cmask ? win[1].r1 : 8'd0;
      res.last_of_frame <= tag5.out_last;
    end
  end

endmodule

// ===== src/ggle_pos.sv =====
// raster position counters for the gray, smoothed and result streams
// depends on ggle_pkg
module ggle_pos #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              acc,
  input  logic                              restart,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]   h,
  output logic [$clog2(MAX_WIDTH)-1:0]      gx,
  output logic [$clog2(MAX_WIDTH)-1:0]      sx,
  output ggle_pkg::tag_t                    tag
);
  import ggle_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int RW = $clog2(MAX_HEIGHT+4) + 1;
  localparam logic signed [RW-1:0] ONE      = RW'(1);
  localparam logic signed [RW-1:0] SROW0    = RW'(-3);
  localparam logic signed [RW-1:0] PROW0    = RW'(-4);

  logic [WW-1:0] gxr, sxr, pxr;
  logic signed [RW-1:0] gyr, syr, pyr;
  logic fresh;

  logic [WW-1:0] gx_c, sx_c, px_c, gx_next, sx_next, px_next;
  logic signed [RW-1:0] gy_c, sy_c, py_c, gy_next, sy_next, py_next;
  logic signed [RW-1:0] hs;

  assign hs = $signed(RW'(h));

  // fresh marks the first item of a frame, positions then start behind by the lag
  always_comb begin
    gx_c = fresh ? '0 : gxr;
    gy_c = fresh ? '0 : gyr;
    sx_c = fresh ? w - WW'(2) : sxr;
    sy_c = fresh ? SROW0 : syr;
    px_c = fresh ? w - WW'(3) : pxr;
    py_c = fresh ? PROW0 : pyr;
  end

  always_comb begin
    if (gx_c == w - WW'(1)) begin
      gx_next = '0;
      gy_next = gy_c + ONE;
    end else begin
      gx_next = gx_c + WW'(1);
      gy_next = gy_c;
    end
    if (sx_c == w - WW'(1)) begin
      sx_next = '0;
      sy_next = sy_c + ONE;
    end else begin
      sx_next = sx_c + WW'(1);
      sy_next = sy_c;
    end
    if (px_c == w - WW'(1)) begin
      px_next = '0;
      py_next = py_c + ONE;
    end else begin
      px_next = px_c + WW'(1);
      py_next = py_c;
    end
  end

  always_comb begin
    tag.smask    = (sx_c >= WW'(2)) && (sx_c <= w - WW'(3)) &&
                   (sy_c >= RW'(2)) && (sy_c <= hs - RW'(3));
    tag.out_vld  = !py_c[RW-1];
    tag.out_last = (px_c == w - WW'(1)) && (py_c == hs - ONE);
    tag.inner    = (px_c >= WW'(1)) && (px_c <= w - WW'(2)) &&
                   (py_c >= ONE) && (py_c <= hs - RW'(2));
    tag.cmask    = (px_c >= WW'(2)) && (px_c <= w - WW'(3)) &&
                   (py_c >= RW'(2)) && (py_c <= hs - RW'(3));
  end

  assign gx = gx_c[CW-1:0];
  assign sx = sx_c[CW-1:0];

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      fresh <= 1'b1;
    end else if (acc) begin
      fresh <= tag.out_last;
      gxr <= gx_next;
      gyr <= gy_next;
      sxr <= sx_next;
      syr <= sy_next;
      pxr <= px_next;
      pyr <= py_next;
    end
  end

endmodule

// ===== src/ggle_gray_col.sv =====
// gray conversion and the gray line memory (four rows per column, read-modify-write)
// gives the vertical 1-4-6-4-1 column sum; depends on ggle_pkg
module ggle_gray_col #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          acc,
  input  ggle_pkg::pix_t                pix,
  input  ggle_pkg::tag_t                tag_in,
  input  logic [$clog2(MAX_WIDTH)-1:0]  gx,
  input  logic [$clog2(MAX_WIDTH)-1:0]  sx_in,
  input  ggle_pkg::weight_t             wr,
  input  ggle_pkg::weight_t             wg,
  input  ggle_pkg::weight_t             wb,
  output logic                          valid3,
  output ggle_pkg::tag_t                tag3,
  output logic [$clog2(MAX_WIDTH)-1:0]  sx3,
  output logic [11:0]                   vsum
);
  import ggle_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  // word holds rows y-1, y-2, y-3, y-4 of one column, newest in the top byte
  logic [31:0] gmem [MAX_WIDTH];

  logic          v1, v2;
  tag_t          tag1, tag2;
  logic [CW-1:0] gx1, gx2, sx1, sx2;
  pix_t          pix1;
  logic [31:0]   col1, col2, col3;
  logic [18:0]   pb, pg, pr;
  logic          flush2;
  logic [7:0]    g3;

  logic [20:0] gsum;
  logic [7:0]  g;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      valid3 <= 1'b0;
    end else if (en) begin
      v1 <= acc;
      v2 <= v1;
      valid3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col1 <= gmem[gx];
      tag1 <= tag_in;
      gx1  <= gx;
      sx1  <= sx_in;
      pix1 <= pix;

      pb     <= 19'(pix1.blue) * 19'(wb);
      pg     <= 19'(pix1.green) * 19'(wg);
      pr     <= 19'(pix1.red) * 19'(wr);
      flush2 <= pix1.flush;
      tag2   <= tag1;
      gx2    <= gx1;
      sx2    <= sx1;
      col2   <= col1;

      g3   <= g;
      col3 <= col2;
      tag3 <= tag2;
      sx3  <= sx2;
    end
    if (en && v2) begin
      gmem[gx2] <= {g, col2[31:8]};
    end
  end

  always_comb begin
    gsum = 21'(pb) + 21'(pg) + 21'(pr);
    if (flush2) begin
      g = '0;
    end else if (gsum[20:18] != 3'd0) begin
      g = 8'd255;
    end else begin
      g = gsum[17:10];
    end
  end

  assign vsum = 12'(g3) + {2'b0, col3[31:24], 2'b0} + 12'(col3[23:16]) * 12'd6 +
                {2'b0, col3[15:8], 2'b0} + 12'(col3[7:0]);

endmodule

// ===== src/ggle_smooth_win.sv =====
// horizontal 5-tap smoothing, smoothed line memory (two rows per column)
// and the 3x3 smoothed window; depends on ggle_pkg
module ggle_smooth_win #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          valid3,
  input  ggle_pkg::tag_t                tag3,
  input  logic [$clog2(MAX_WIDTH)-1:0]  sx3,
  input  logic [11:0]                   vsum,
  output logic                          valid5,
  output ggle_pkg::tag_t                tag5,
  output ggle_pkg::scol_t [2:0]         win
);
  import ggle_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  // word holds rows y-1 and y-2 of one smoothed column
  logic [15:0] smem [MAX_WIDTH];

  logic          v4;
  tag_t          tag4;
  logic [CW-1:0] sx4;
  logic [11:0]   vwin [5];
  logic [15:0]   srd;

  logic [15:0] hsum;
  logic [7:0]  s;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      valid5 <= 1'b0;
    end else if (en) begin
      v4 <= valid3;
      valid5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      srd  <= smem[sx3];
      tag4 <= tag3;
      sx4  <= sx3;
      tag5 <= tag4;
    end
    if (en && valid3) begin
      vwin[0] <= vsum;
      for (int i = 1; i < 5; i++) begin
        vwin[i] <= vwin[i-1];
      end
    end
    if (en && v4) begin
      smem[sx4] <= {s, srd[15:8]};
      win[2] <= win[1];
      win[1] <= win[0];
      win[0] <= '{r0: s, r1: srd[15:8], r2: srd[7:0]};
    end
  end

  always_comb begin
    hsum = 16'(vwin[0]) + {2'b0, vwin[1], 2'b0} + 16'(vwin[2]) * 16'd6 +
           {2'b0, vwin[3], 2'b0} + 16'(vwin[4]);
    s = tag4.smask ? hsum[15:8] : 8'd0;
  end

endmodule

// ===== src/ggle_checker.sv =====
// port-level checks for the edge mask unit, bound to the top level
// depends on ggle_pkg and gray_gauss_laplace_edge_mask_unit
module ggle_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             pix_ready,
  input logic                             res_valid,
  input logic                             res_ready,
  input ggle_pkg::res_t                   res
);
  import ggle_pkg::*;

  // a stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  // input is held off while a result waits
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !pix_ready)
    else $error("input taken while output stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result beat right after reset");

  // the bottom-right pixel lies in the border
  a_last_border: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.last_of_frame |-> res.smoothed == 8'd0 && !res.edge_res)
    else $error("last pixel of frame not in border");

endmodule

bind gray_gauss_laplace_edge_mask_unit ggle_checker u_ggle_checker (.*);
